>>> rtl/core/stlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared types and codes for the segmented TLB / LRU paging block.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int SEG_COUNT  = 3;
    localparam int SEG_W      = 2;
    localparam int PAGE_W     = 8;
    localparam int BYTES_W    = 18;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int DELAY_W    = 40;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_W     = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 192;

    // page size in bytes; a power of two so the page count is a shift
    localparam int PAGE_BYTES = 1024;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SEG0 = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEG1 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEG2 = 2'd2;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OC_INVALID    = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_TLB_HIT    = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_TLB_MISS   = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_FAULT_FREE = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_FAULT_EVICT = 3'd4;

    localparam logic [SEG_W-1:0] SEG_INVALID = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/stlb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/stlb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlb_ctrl
// Sequencer: take a word, scan TLB and frame table, update, emit result.
// ----------------------------------------------------------------------------
module stlb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  stlb_pkg::t_sts i_sts,
    output stlb_pkg::t_cmd o_cmd
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_SCAN;
            ST_SCAN:   if (i_sts.scan_done) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_EMIT;
            ST_EMIT:   if (i_sts.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.update = (r_state == ST_UPDATE);
    assign o_cmd.emit   = (r_state == ST_EMIT) && i_sts.out_free;

    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SCAN) else $error("load did not start scan");
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> !o_cmd.update) else $error("update repeated");
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == ST_IDLE) else $error("emit did not return to idle");
endmodule

>>> rtl/core/stlb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlb_datapath
// TLB FIFO, per-segment frame tables, scan logic, counters and result word.
// ----------------------------------------------------------------------------
module stlb_datapath #(
    parameter int TLB_ENTRIES = 64,
    parameter int MAX_FRAMES  = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic [stlb_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [stlb_pkg::BYTES_W-1:0]            i_cfg_data,
    input  logic [stlb_pkg::SEG_W-1:0]              i_seg,
    input  logic [stlb_pkg::PAGE_W-1:0]             i_page,
    input  stlb_pkg::t_cmd                          i_cmd,
    output stlb_pkg::t_sts                          o_sts,
    input  logic                                    i_m_tready,
    output logic                                    o_m_tvalid,
    output logic [stlb_pkg::M_DATA_W-1:0]           o_m_tdata
);
    localparam int TW  = TLB_ENTRIES > 1 ? $clog2(TLB_ENTRIES) : 1;
    localparam int FW  = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
    localparam int FD  = stlb_pkg::SEG_COUNT * MAX_FRAMES;
    localparam int AW  = $clog2(FD);
    localparam int LW  = $clog2((TLB_ENTRIES > MAX_FRAMES ? TLB_ENTRIES : MAX_FRAMES) + 1);
    localparam int PBW = $clog2(stlb_pkg::PAGE_BYTES);
    localparam int PCW = stlb_pkg::BYTES_W + 1;
    localparam int TLBD_W = stlb_pkg::SEG_W + stlb_pkg::PAGE_W;
    localparam int FRMD_W = stlb_pkg::PAGE_W + stlb_pkg::TIME_W;
    localparam int SUM_W  = stlb_pkg::DELAY_W + 2;

    // slot 0 of each segment starts out valid
    function automatic logic [FD-1:0] valid_init();
        logic [FD-1:0] v;
        v = '0;
        for (int s = 0; s < stlb_pkg::SEG_COUNT; s++) begin
            v[s * MAX_FRAMES] = 1'b1;
        end
        return v;
    endfunction

    localparam logic [FD-1:0] VALID_INIT = valid_init();

    // configuration
    logic [stlb_pkg::BYTES_W-1:0] r_bytes [stlb_pkg::SEG_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stlb_pkg::SEG_COUNT; i++) begin
                r_bytes[i] <= stlb_pkg::BYTES_W'(1024);
            end
        end else if (i_cfg_valid) begin
            priority case (i_cfg_addr)
                stlb_pkg::CFG_SEG0: r_bytes[0] <= i_cfg_data;
                stlb_pkg::CFG_SEG1: r_bytes[1] <= i_cfg_data;
                stlb_pkg::CFG_SEG2: r_bytes[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // page and frame counts of the incoming segment
    logic [stlb_pkg::BYTES_W-1:0] w_bytes;
    logic [PCW-1:0]               w_pages;
    logic [PCW-1:0]               w_nf_raw;
    logic [LW-1:0]                w_nf;
    logic                         w_ref_ok;

    always_comb begin
        w_bytes  = (i_seg == stlb_pkg::SEG_INVALID) ? '0 : r_bytes[i_seg];
        w_pages  = (PCW'(w_bytes) + PCW'(stlb_pkg::PAGE_BYTES - 1)) >> PBW;
        w_nf_raw = (w_pages + PCW'(1)) >> 1;
        w_nf     = (w_nf_raw > PCW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(w_nf_raw);
        w_ref_ok = (i_seg != stlb_pkg::SEG_INVALID) && (PCW'(i_page) < w_pages);
    end

    // item and scan registers
    logic [stlb_pkg::SEG_W-1:0]  r_seg;
    logic [stlb_pkg::PAGE_W-1:0] r_page;
    logic                        r_ok;
    logic [LW-1:0]               r_nf;
    logic [LW-1:0]               r_lim;
    logic [LW-1:0]               r_idx;
    logic [LW-1:0]               r_pidx;
    logic                        r_pv;
    logic                        r_hit;
    logic                        r_found;
    logic [FW-1:0]               r_found_slot;
    logic                        r_free;
    logic [FW-1:0]               r_free_slot;
    logic [FW-1:0]               r_best_slot;
    logic [stlb_pkg::TIME_W-1:0] r_best_time;
    logic [stlb_pkg::PAGE_W-1:0] r_best_page;

    // TLB FIFO pointers and frame table flags
    logic [TW-1:0]               r_head;
    logic [LW-1:0]               r_fill;
    logic [FD-1:0]               r_valid;
    logic [FD-1:0]               r_wr;
    logic [stlb_pkg::TIME_W-1:0] r_time;

    logic [stlb_pkg::CNT_W-1:0]  r_hits;
    logic [stlb_pkg::CNT_W-1:0]  r_misses;
    logic [stlb_pkg::CNT_W-1:0]  r_faults;
    logic [stlb_pkg::CNT_W-1:0]  r_invalid;

    // memory ports
    logic [TW-1:0]      w_tlb_raddr;
    logic [TW-1:0]      w_tlb_waddr;
    logic               w_tlb_we;
    logic [TLBD_W-1:0]  w_tlb_q;
    logic [AW-1:0]      w_frm_base;
    logic [AW-1:0]      w_frm_raddr;
    logic [AW-1:0]      w_frm_waddr;
    logic               w_frm_we;
    logic [FRMD_W-1:0]  w_frm_q;
    logic [AW-1:0]      w_pa;

    // map logical TLB position onto the circular buffer
    function automatic logic [TW-1:0] tlb_wrap(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (TW+1)'(TLB_ENTRIES)) begin
            s = s - (TW+1)'(TLB_ENTRIES);
        end
        return s[TW-1:0];
    endfunction

    assign w_frm_base  = AW'(r_seg) * AW'(MAX_FRAMES);
    assign w_tlb_raddr = tlb_wrap(r_head, r_idx[TW-1:0]);
    assign w_frm_raddr = w_frm_base + AW'(r_idx[FW-1:0]);
    assign w_pa        = w_frm_base + AW'(r_pidx[FW-1:0]);

    stlb_ram #(.WIDTH(TLBD_W), .DEPTH(TLB_ENTRIES)) u_tlb_ram (
        .i_clk   (i_clk),
        .i_we    (w_tlb_we),
        .i_waddr (w_tlb_waddr),
        .i_wdata ({r_seg, r_page}),
        .i_raddr (w_tlb_raddr),
        .o_rdata (w_tlb_q)
    );

    stlb_ram #(.WIDTH(FRMD_W), .DEPTH(FD)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_frm_we),
        .i_waddr (w_frm_waddr),
        .i_wdata ({r_page, r_time}),
        .i_raddr (w_frm_raddr),
        .o_rdata (w_frm_q)
    );

    // entry read back from the frame table; never written reads as page 0, time 0
    logic                        w_pvalid;
    logic [stlb_pkg::PAGE_W-1:0] w_ppage;
    logic [stlb_pkg::TIME_W-1:0] w_ptime;

    always_comb begin
        w_pvalid = r_valid[w_pa];
        w_ppage  = r_wr[w_pa] ? w_frm_q[FRMD_W-1 -: stlb_pkg::PAGE_W] : '0;
        w_ptime  = r_wr[w_pa] ? w_frm_q[stlb_pkg::TIME_W-1:0] : '0;
    end

    assign o_sts.scan_done = (r_idx >= r_lim) && !r_pv;

    // update decision
    logic                           w_is_fault;
    logic [FW-1:0]                  w_slot;
    logic [stlb_pkg::OUTCOME_W-1:0] w_outcome;

    always_comb begin
        w_is_fault = r_ok && !r_hit && !r_found;
        w_slot     = r_found ? r_found_slot : (r_free ? r_free_slot : r_best_slot);
        priority if (!r_ok) begin
            w_outcome = stlb_pkg::OC_INVALID;
        end else if (r_hit) begin
            w_outcome = stlb_pkg::OC_TLB_HIT;
        end else if (r_found) begin
            w_outcome = stlb_pkg::OC_TLB_MISS;
        end else if (r_free) begin
            w_outcome = stlb_pkg::OC_FAULT_FREE;
        end else begin
            w_outcome = stlb_pkg::OC_FAULT_EVICT;
        end
        w_frm_we    = i_cmd.update && r_ok && (r_found || w_is_fault);
        w_frm_waddr = w_frm_base + AW'(w_slot);
        w_tlb_we    = i_cmd.update && r_ok && !r_hit && r_found;
        w_tlb_waddr = (r_fill < LW'(TLB_ENTRIES)) ? tlb_wrap(r_head, r_fill[TW-1:0]) : r_head;
    end

    function automatic logic [stlb_pkg::CNT_W-1:0] sat_inc(input logic [stlb_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + stlb_pkg::CNT_W'(1);
    endfunction

    // scan, update and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_lim     <= '0;
            r_pv      <= 1'b0;
            r_head    <= '0;
            r_fill    <= '0;
            r_time    <= stlb_pkg::TIME_W'(1);
            r_hits    <= '0;
            r_misses  <= '0;
            r_faults  <= '0;
            r_invalid <= '0;
            r_valid   <= VALID_INIT;
            r_wr      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_seg   <= i_seg;
                r_page  <= i_page;
                r_ok    <= w_ref_ok;
                r_nf    <= w_nf;
                r_lim   <= !w_ref_ok ? '0 : ((r_fill > w_nf) ? r_fill : w_nf);
                r_idx   <= '0;
                r_pv    <= 1'b0;
                r_hit   <= 1'b0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end
            if (i_cmd.scan) begin
                // issue the next address
                r_pv   <= (r_idx < r_lim);
                r_pidx <= r_idx;
                if (r_idx < r_lim) begin
                    r_idx <= r_idx + LW'(1);
                end
                // compare what came back
                if (r_pv) begin
                    if (r_pidx < r_fill && w_tlb_q == {r_seg, r_page}) begin
                        r_hit <= 1'b1;
                    end
                    if (r_pidx < r_nf) begin
                        if (w_pvalid && w_ppage == r_page && !r_found) begin
                            r_found      <= 1'b1;
                            r_found_slot <= r_pidx[FW-1:0];
                        end
                        if (!w_pvalid && !r_free) begin
                            r_free      <= 1'b1;
                            r_free_slot <= r_pidx[FW-1:0];
                        end
                        if (r_pidx == '0 || w_ptime < r_best_time) begin
                            r_best_slot <= r_pidx[FW-1:0];
                            r_best_time <= w_ptime;
                            r_best_page <= w_ppage;
                        end
                    end
                end
            end
            if (i_cmd.update) begin
                if (r_time != '1) begin
                    r_time <= r_time + stlb_pkg::TIME_W'(1);
                end
                if (!r_ok) begin
                    r_invalid <= sat_inc(r_invalid);
                end else if (r_hit) begin
                    r_hits <= sat_inc(r_hits);
                end else begin
                    r_misses <= sat_inc(r_misses);
                    if (w_is_fault) begin
                        r_faults <= sat_inc(r_faults);
                    end
                end
                if (w_frm_we) begin
                    r_valid[w_frm_waddr] <= 1'b1;
                    r_wr[w_frm_waddr]    <= 1'b1;
                end
                if (w_tlb_we) begin
                    if (r_fill < LW'(TLB_ENTRIES)) begin
                        r_fill <= r_fill + LW'(1);
                    end else begin
                        r_head <= tlb_wrap(r_head, TW'(1));
                    end
                end
            end
        end
    end

    // result fields latched at update
    logic [stlb_pkg::OUTCOME_W-1:0] r_res_outcome;
    logic [stlb_pkg::SLOT_W-1:0]    r_res_slot;
    logic [stlb_pkg::PAGE_W-1:0]    r_res_evict;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_outcome <= w_outcome;
            r_res_slot    <= (r_found || w_is_fault) ? stlb_pkg::SLOT_W'(w_slot) : '0;
            r_res_evict   <= (w_outcome == stlb_pkg::OC_FAULT_EVICT) ? r_best_page : '0;
        end
    end

    // weighted delay
    logic [stlb_pkg::CNT_W-1:0]   w_nonfault;
    logic [SUM_W-1:0]             w_sum;
    logic [stlb_pkg::DELAY_W-1:0] w_delay;

    always_comb begin
        w_nonfault = (r_misses >= r_faults) ? r_misses - r_faults : '0;
        w_sum = SUM_W'(r_faults) * SUM_W'(100) + SUM_W'(w_nonfault) * SUM_W'(10)
              + SUM_W'(r_hits);
        w_delay = (w_sum > SUM_W'({stlb_pkg::DELAY_W{1'b1}})) ? '1
                                                               : w_sum[stlb_pkg::DELAY_W-1:0];
    end

    // output register
    logic r_out_vld;
    logic [stlb_pkg::M_DATA_W-1:0] r_out_data;

    assign o_sts.out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {7'd0, w_delay, r_invalid, r_faults, r_misses, r_hits,
                           r_res_evict, r_res_slot, r_res_outcome};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(TLB_ENTRIES)) else $error("TLB fill beyond depth");
    a_time_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time != '0) else $error("reference time wrapped");
    a_slot0_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0]) else $error("slot 0 of segment 0 lost valid");
    a_faults_le_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_faults <= r_misses) else $error("faults exceed misses");
endmodule

>>> rtl/core/segmented_tlb_lru_paging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_tlb_lru_paging
// Segmented paging with a FIFO TLB and per-segment LRU frame tables.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_tvalid / o_s_tready      segment_number, page_number
//  m_axis    out  o_m_tvalid / i_m_tready      outcome .. total_delay
//  cfg       in   i_cfg_valid / o_cfg_ready    register index, byte count
//
//  A valid reference scans max(TLB fill, segment frame count) entries, an
//  invalid one skips the scan; the result word becomes valid as the control
//  returns to idle, where the next word can be taken. The TLB and the frame
//  table are read one entry per cycle through their RAM ports.
//  Reset is synchronous; the TLB is empty and only slot 0 of each segment is valid at once.
//  A waiting result is held in the output register; the next word is taken
//  meanwhile and held in the emit step until the result is drained.
// ----------------------------------------------------------------------------
module segmented_tlb_lru_paging #(
    parameter int TLB_ENTRIES = 64,
    parameter int MAX_FRAMES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] segment_number, [9:2] page_number
    input  logic [15:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] outcome, [8:3] frame_slot, [16:9] evicted_page, [48:17] total_hits,
    // [80:49] total_misses, [112:81] total_faults, [144:113] total_invalid,
    // [184:145] total_delay
    output logic [191:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_data
);
    stlb_pkg::t_cmd w_cmd;
    stlb_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    stlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stlb_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_seg       (i_s_tdata[1:0]),
        .i_page      (i_s_tdata[9:2]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );
endmodule
